### src/qlt_pkg.sv
// Shared types, codes and character helpers for the quoted line tokenizer.
`default_nettype none
package qlt_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_END    = 2'd1,
      KIND_SEP    = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   // Line status codes
   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_QUOTE_AFTER  = 2'd1,
      ST_UNTERMINATED = 2'd2
   } status_type;

   // Running number class of the open token
   typedef enum logic [2:0] {
      CLS_EMPTY   = 3'd0,
      CLS_ZERO    = 3'd1,
      CLS_HEX_PFX = 3'd2,
      CLS_HEX     = 3'd3,
      CLS_OCT     = 3'd4,
      CLS_DEC     = 3'd5,
      CLS_NAN     = 3'd6
   } class_type;

   // Characters with a meaning of their own
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // Result queue depth
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_out;
      logic       token_class;
      status_type status;
      logic       last;
   } rec_type;

   // Up to two results produced by one accepted item
   typedef struct packed {
      logic [1:0] num;
      rec_type    r0;
      rec_type    r1;
   } push_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_SEVEN);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09) ||
             (c == 8'h0C) || (c == 8'h0B);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_EQUAL) || (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA);
   endfunction

   function automatic class_type next_class(input class_type cls, input logic [7:0] c);
      class_type nxt;
      unique case (cls)
         CLS_EMPTY:           nxt = (c == CH_ZERO) ? CLS_ZERO : (is_dec(c) ? CLS_DEC : CLS_NAN);
         CLS_ZERO:            nxt = (c == CH_LOW_X) ? CLS_HEX_PFX : (is_oct(c) ? CLS_OCT : CLS_NAN);
         CLS_HEX_PFX, CLS_HEX: nxt = is_hex(c) ? CLS_HEX : CLS_NAN;
         CLS_OCT:             nxt = is_oct(c) ? CLS_OCT : CLS_NAN;
         CLS_DEC:             nxt = is_dec(c) ? CLS_DEC : CLS_NAN;
         default:             nxt = CLS_NAN;
      endcase
      return nxt;
   endfunction

   function automatic logic class_is_number(input class_type cls);
      return (cls == CLS_ZERO) || (cls == CLS_HEX) || (cls == CLS_OCT) || (cls == CLS_DEC);
   endfunction

   function automatic rec_type make_rec(input kind_type kind, input logic [7:0] b,
                                        input logic cls, input status_type st);
      rec_type r;
      r.kind        = kind;
      r.byte_out    = b;
      r.token_class = cls;
      r.status      = st;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

### src/qlt_if.sv
// Handshake channels for request characters and tokenizer results.
`default_nettype none
interface qlt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_line_end;

   modport source (output valid, output ch, output is_line_end, input ready);
   modport sink   (input valid, input ch, input is_line_end, output ready);
endinterface

interface qlt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_out;
   logic       token_class;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output kind, output byte_out, output token_class,
                   output status, output last, input ready);
   modport sink   (input valid, input kind, input byte_out, input token_class,
                   input status, input last, output ready);
endinterface
`default_nettype wire

### src/qlt_lexer.sv
// Per-character lexer state and decode of up to two results per item.
`default_nettype none
module qlt_lexer (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     ch,
   input  wire logic           is_line_end,
   output qlt_pkg::push_type   push
);
   import qlt_pkg::*;

   logic       in_quoted_ff, in_quoted_in;
   logic       skip_rest_ff, skip_rest_in;
   status_type line_error_ff, line_error_in;
   logic       token_open_ff, token_open_in;
   class_type  number_class_ff, number_class_in;

   rec_type    res [2];
   logic [1:0] cnt;
   logic       cls_num;
   status_type st;

   // Decode one item against the current line state
   always_comb begin
      in_quoted_in    = in_quoted_ff;
      skip_rest_in    = skip_rest_ff;
      line_error_in   = line_error_ff;
      token_open_in   = token_open_ff;
      number_class_in = number_class_ff;
      res[0]          = '0;
      res[1]          = '0;
      cnt             = 2'd0;
      cls_num         = class_is_number(number_class_ff);
      st              = ST_OK;

      if (is_line_end) begin
         if (skip_rest_ff) begin
            st = line_error_ff;
         end else if (in_quoted_ff) begin
            st = ST_UNTERMINATED;
         end else begin
            st = ST_OK;
            if (token_open_ff) begin
               res[cnt[0]] = make_rec(KIND_END, 8'h00, cls_num, ST_OK);
               cnt         = cnt + 2'd1;
            end
         end
         res[cnt[0]]     = make_rec(KIND_STATUS, 8'h00, 1'b0, st);
         cnt             = cnt + 2'd1;
         in_quoted_in    = 1'b0;
         skip_rest_in    = 1'b0;
         line_error_in   = ST_OK;
         token_open_in   = 1'b0;
         number_class_in = CLS_EMPTY;
      end else if (skip_rest_ff) begin
         cnt = 2'd0;
      end else if (in_quoted_ff) begin
         if (ch == CH_QUOTE) begin
            res[0]          = make_rec(KIND_END, 8'h00, 1'b0, ST_OK);
            cnt             = 2'd1;
            in_quoted_in    = 1'b0;
            token_open_in   = 1'b0;
            number_class_in = CLS_EMPTY;
         end else begin
            res[0] = make_rec(KIND_BYTE, ch, 1'b0, ST_OK);
            cnt    = 2'd1;
         end
      end else if (ch == CH_QUOTE) begin
         if (token_open_ff) begin
            line_error_in = ST_QUOTE_AFTER;
            skip_rest_in  = 1'b1;
         end else begin
            in_quoted_in    = 1'b1;
            token_open_in   = 1'b1;
            number_class_in = CLS_EMPTY;
         end
      end else if (ch == CH_HASH || is_space(ch) || is_sep(ch)) begin
         // Close any open token, then handle the delimiter itself
         if (token_open_ff) begin
            res[cnt[0]] = make_rec(KIND_END, 8'h00, cls_num, ST_OK);
            cnt         = cnt + 2'd1;
         end
         token_open_in   = 1'b0;
         number_class_in = CLS_EMPTY;
         if (ch == CH_HASH) begin
            skip_rest_in = 1'b1;
         end else if (is_sep(ch)) begin
            res[cnt[0]] = make_rec(KIND_SEP, ch, 1'b0, ST_OK);
            cnt         = cnt + 2'd1;
         end
      end else begin
         res[0]          = make_rec(KIND_BYTE, ch, 1'b0, ST_OK);
         cnt             = 2'd1;
         number_class_in = next_class(number_class_ff, ch);
         token_open_in   = 1'b1;
      end

      // Flag the final result of this item
      if (cnt == 2'd1) begin
         res[0].last = 1'b1;
      end else if (cnt == 2'd2) begin
         res[1].last = 1'b1;
      end
   end

   assign push.num = accept ? cnt : 2'd0;
   assign push.r0  = res[0];
   assign push.r1  = res[1];

   // Advance line state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_quoted_ff    <= 1'b0;
         skip_rest_ff    <= 1'b0;
         line_error_ff   <= ST_OK;
         token_open_ff   <= 1'b0;
         number_class_ff <= CLS_EMPTY;
      end else if (accept) begin
         in_quoted_ff    <= in_quoted_in;
         skip_rest_ff    <= skip_rest_in;
         line_error_ff   <= line_error_in;
         token_open_ff   <= token_open_in;
         number_class_ff <= number_class_in;
      end
   end

endmodule
`default_nettype wire

### src/qlt_res_queue.sv
// Small result queue: takes up to two results a cycle, delivers one.
`default_nettype none
module qlt_res_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  qlt_pkg::push_type              push,
   input  wire logic                      pop,
   output qlt_pkg::rec_type               head,
   output logic                           not_empty,
   output logic [qlt_pkg::QueueCntW-1:0]  count
);
   import qlt_pkg::*;

   rec_type              entry_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;
   logic [QueuePtrW-1:0] wr_next;

   assign wr_next = wr_ptr_ff + QueuePtrW'(1);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(push.num);
      rd_ptr_in = rd_ptr_ff + QueuePtrW'(pop);
      count_in  = count_ff + QueueCntW'(push.num) - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store results at the tail
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_next] <= push.r1;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule
`default_nettype wire

### src/quoted_line_tokenizer.sv
// Top level of the quoted line tokenizer.
// Takes one character per item (or a terminator item) and streams token bytes, token ends
// with a number/string class, separator tokens and a line status on the result channel.
// Each item is decoded combinationally against the line state and its results are
// written into a four-entry result queue; the first result can be taken the cycle after
// the item is accepted. An item is accepted every cycle while the queue has room for two
// results, so items that give at most one result flow at one per cycle while results are
// taken; an item that gives two results (token end plus separator, or token end plus line
// status) needs the single result port for each result; that port sets the sustained rate.
`default_nettype none
module quoted_line_tokenizer (
   input  wire logic  clock,
   input  wire logic  reset,
   qlt_req_if.sink    req_chan,
   qlt_rsp_if.source  rsp_chan
);
   import qlt_pkg::*;

   logic                 accept;
   logic                 pop;
   push_type             push;
   rec_type              head;
   logic                 not_empty;
   logic [QueueCntW-1:0] count;

   // Take an item while two queue slots are free
   assign req_chan.ready = (count <= QueueCntW'(QueueDepth - 2));
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   qlt_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_chan.ch),
      .is_line_end (req_chan.is_line_end),
      .push        (push)
   );

   qlt_res_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .count     (count)
   );

   assign rsp_chan.valid       = not_empty;
   assign rsp_chan.kind        = head.kind;
   assign rsp_chan.byte_out    = head.byte_out;
   assign rsp_chan.token_class = head.token_class;
   assign rsp_chan.status      = head.status;
   assign rsp_chan.last        = head.last;

endmodule
`default_nettype wire

### src/qlt_checker.sv
// Port-level checks on the tokenizer result stream, bound to the top level.
`default_nettype none
module qlt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_byte_out,
   input wire logic       rsp_token_class,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_last
);
   import qlt_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_byte_out))
      else $error("result changed while stalled");

   // Drop all results on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only a token end may be followed by another result of the same item
   a_last_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_END) |-> rsp_last)
      else $error("byte, separator or status result not marked last");

   // Token ends and statuses carry no byte; only statuses carry a status
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END || rsp_kind == KIND_STATUS) |->
         (rsp_byte_out == 8'h00) && (rsp_kind == KIND_STATUS || rsp_status == ST_OK) &&
         (rsp_kind == KIND_END || !rsp_token_class))
      else $error("stray field value on token end or status result");

endmodule

bind quoted_line_tokenizer qlt_checker u_qlt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_byte_out    (rsp_chan.byte_out),
   .rsp_token_class (rsp_chan.token_class),
   .rsp_status      (rsp_chan.status),
   .rsp_last        (rsp_chan.last)
);
`default_nettype wire
